// File: src/utf8_devanagari_histogram_assert.svh
// Assertion macros shared by the histogram checker.
// Depends on nothing; included by files that assert.
`ifndef UTF8_DEVANAGARI_HISTOGRAM_ASSERT_SVH
`define UTF8_DEVANAGARI_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UDH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/udh_pkg.sv
// Package for the UTF-8 Devanagari histogram: widths, byte codes, op kinds.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package udh_pkg;

   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int BIN_DEPTH          = 512;
   localparam int BIN_ADDR_W         = 9;
   localparam int RESULT_COUNT_W     = 32;
   localparam int REQ_TDATA_W        = 24;
   localparam int RSP_TDATA_W        = 48;

   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;

   localparam logic [7:0] DEVA_LEAD   = 8'hE0;
   localparam logic [7:0] DEVA_LOW    = 8'hA4;
   localparam logic [7:0] DEVA_HIGH   = 8'hA5;
   localparam logic [7:0] DANDA_FIRST = 8'hA4;
   localparam logic [7:0] DANDA_LAST  = 8'hA5;
   localparam logic [7:0] DIGIT_FIRST = 8'hA6;
   localparam logic [7:0] DIGIT_LAST  = 8'hAF;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] CTRL_WS_LO = 8'h09;
   localparam logic [7:0] CTRL_WS_HI = 8'h0D;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_COUNT
   } op_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == SPACE_CHAR) || ((b >= CTRL_WS_LO) && (b <= CTRL_WS_HI));
   endfunction

   function automatic logic [1:0] extra_bytes(input logic [7:0] lead);
      logic [1:0] n;
      if ((lead & LEAD4_MASK) == LEAD4_CODE) n = 2'd3;
      else if ((lead & LEAD3_MASK) == LEAD3_CODE) n = 2'd2;
      else if ((lead & LEAD2_MASK) == LEAD2_CODE) n = 2'd1;
      else n = 2'd0;
      return n;
   endfunction

endpackage

`default_nettype wire

// File: src/utf8_devanagari_histogram.sv
// Usage notes for the UTF-8 Devanagari character histogram.
// Input stream (req_): one transaction is a text byte (req_tuser = 0) or a
// bin read (req_tuser = 1). Text bytes are decoded as UTF-8 split at
// whitespace; each counted Devanagari character bumps a saturating count in a
// 512-entry single-port-write, one-read synchronous memory.
// Result stream (rsp_): exactly one transaction per request, in order.
// rsp_tuser is 1 when the byte completed a counted character; rsp_tdata
// carries the bin index and its count (low 32 bits) or zeros.
// Path: a request is registered into the first stage, then moves to the
// result register, from which its result is offered on the rsp_ stream.
// Throughput: one request per cycle when not stalled or clearing; the memory
// read sits in the first stage, the increment and write-back in the second,
// with the last write forwarded to a following read of the same bin.
// Reset: after reset is released, a clearing pass writes zero to all 512
// bins, one per cycle; req_tready stays low until the pass is done.
// Stall: while rsp_tready is low the result register holds; one more request
// is taken into the first stage, then req_tready drops until space frees.
// Depends on udh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8_devanagari_histogram
   import udh_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // text_byte[7:0], read_bin[16:8], zero pad
   input  wire logic                   req_tuser,  // command[0]
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,  // bin_index[8:0], bin_count[40:9], zero pad
   output      logic                   rsp_tuser   // counted[0]
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int PAD_W = RSP_TDATA_W - BIN_ADDR_W - RESULT_COUNT_W;

   logic [COUNT_BITS-1:0] bin_mem [BIN_DEPTH];
   logic [COUNT_BITS-1:0] mem_rdata_ff;

   logic [1:0] skip_ff, skip_in;
   logic       cand_ff, cand_in;
   logic [7:0] held_ff, held_in;

   logic                  clearing_ff;
   logic [BIN_ADDR_W-1:0] clr_addr_ff;

   logic                  s1_valid_ff, s1_valid_in;
   op_type                s1_op_ff;
   logic [BIN_ADDR_W-1:0] s1_idx_ff;

   logic                  last_wr_valid_ff;
   logic [BIN_ADDR_W-1:0] last_wr_addr_ff;
   logic [COUNT_BITS-1:0] last_wr_data_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_tdata_ff;
   logic                   out_tuser_ff;

   logic                  accept;
   logic                  out_free;
   logic                  s1_move;
   op_type                op0;
   logic [BIN_ADDR_W-1:0] idx0;
   logic [7:0]            in_byte;
   logic                  upper;
   logic                  digit;
   logic                  danda;

   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;
   logic [COUNT_BITS-1:0] res_count;
   logic [63:0]           res_wide;

   logic                  mem_we;
   logic [BIN_ADDR_W-1:0] mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !clearing_ff && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;
   assign in_byte    = req_tdata[7:0];

   assign upper = (held_ff == DEVA_HIGH);
   assign digit = upper && (in_byte >= DIGIT_FIRST) && (in_byte <= DIGIT_LAST);
   assign danda = upper && ((in_byte == DANDA_FIRST) || (in_byte == DANDA_LAST));

   // decode the request and advance the sequence state
   always_comb begin
      skip_in = skip_ff;
      cand_in = cand_ff;
      held_in = held_ff;
      op0     = OP_NONE;
      idx0    = '0;
      if (accept) begin
         if (req_tuser == CMD_READ) begin
            op0  = OP_READ;
            idx0 = req_tdata[16:8];
         end else if (is_space(in_byte)) begin
            skip_in = 2'd0;
            cand_in = 1'b0;
            held_in = 8'h00;
         end else if (skip_ff == 2'd0) begin
            skip_in = extra_bytes(in_byte);
            cand_in = (in_byte == DEVA_LEAD);
            held_in = 8'h00;
         end else begin
            if ((skip_ff == 2'd2) && cand_ff) begin
               held_in = in_byte;
               if ((in_byte != DEVA_LOW) && (in_byte != DEVA_HIGH)) begin
                  cand_in = 1'b0;
               end
            end else if ((skip_ff == 2'd1) && cand_ff) begin
               if (!digit && !danda) begin
                  op0  = OP_COUNT;
                  idx0 = {upper, in_byte};
               end
               cand_in = 1'b0;
            end
            skip_in = skip_ff - 2'd1;
         end
      end
   end

   // forward the last write-back over the stale memory read
   assign cur_count = (last_wr_valid_ff && (last_wr_addr_ff == s1_idx_ff)) ?
                      last_wr_data_ff : mem_rdata_ff;
   assign new_count = (cur_count == COUNT_MAX) ? cur_count :
                      cur_count + COUNT_BITS'(1);

   always_comb begin
      case (s1_op_ff)
         OP_COUNT: res_count = new_count;
         OP_READ:  res_count = cur_count;
         default:  res_count = '0;
      endcase
   end

   assign res_wide = 64'(res_count);

   assign mem_we    = clearing_ff || (s1_move && (s1_op_ff == OP_COUNT));
   assign mem_waddr = clearing_ff ? clr_addr_ff : s1_idx_ff;
   assign mem_wdata = clearing_ff ? '0 : new_count;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         mem_rdata_ff <= bin_mem[idx0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff          <= 2'd0;
         cand_ff          <= 1'b0;
         held_ff          <= 8'h00;
         clearing_ff      <= 1'b1;
         clr_addr_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         skip_ff      <= skip_in;
         cand_ff      <= cand_in;
         held_ff      <= held_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + BIN_ADDR_W'(1);
            if (clr_addr_ff == BIN_ADDR_W'(BIN_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
            last_wr_valid_ff <= 1'b0;
         end else if (mem_we) begin
            last_wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff  <= op0;
         s1_idx_ff <= idx0;
      end
      if (!clearing_ff && mem_we) begin
         last_wr_addr_ff <= mem_waddr;
         last_wr_data_ff <= mem_wdata;
      end
      if (s1_move) begin
         out_tdata_ff <= {PAD_W'(0), res_wide[RESULT_COUNT_W-1:0],
                          (s1_op_ff == OP_NONE) ? BIN_ADDR_W'(0) : s1_idx_ff};
         out_tuser_ff <= (s1_op_ff == OP_COUNT);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_tdata_ff;
   assign rsp_tuser  = out_tuser_ff;

endmodule

`default_nettype wire

// File: src/udh_checker.sv
// Port-level checker for the UTF-8 Devanagari histogram, bound to the top.
// Depends on udh_pkg and utf8_devanagari_histogram_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_devanagari_histogram_assert.svh"

module udh_checker
   import udh_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser
);

   logic not_counted_code;

   assign not_counted_code = rsp_tdata[8] && (rsp_tdata[7:0] >= DANDA_FIRST) &&
                             (rsp_tdata[7:0] <= DIGIT_LAST);

   `UDH_ASSERT_NOW(a_no_digit_danda, clock, reset, rsp_tvalid && rsp_tuser,
                   !not_counted_code, "digit or danda reported as counted")
   `UDH_ASSERT_NOW(a_clear_blocks_input, clock, reset, $past(reset), !req_tready,
                   "input taken before clearing pass")
   `UDH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
                    "stalled result changed")

endmodule

bind utf8_devanagari_histogram udh_checker u_udh_checker (.*);

`default_nettype wire
